FILE: rtl/core/tpr_pkg.sv
// Shared types, constants and helpers for the telemetry poll responder.
// No dependencies; imported by every module of the block.
package tpr_pkg;

   localparam int SLOTS_DEF = 16;

   localparam logic [7:0] STUFF_ESC  = 8'h7D;
   localparam logic [7:0] STUFF_FLAG = 8'h7E;
   localparam logic [7:0] STUFF_XOR  = 8'h20;

   // register indexes on the configuration port (paddr[3:2])
   localparam logic [1:0] REG_PHYS_ID  = 2'd0;
   localparam logic [1:0] REG_START    = 2'd1;
   localparam logic [1:0] REG_HDR_DATA = 2'd2;
   localparam logic [1:0] REG_HDR_DISC = 2'd3;

   typedef struct packed {
      logic        kind;
      logic [7:0]  rx_byte;
      logic [3:0]  slot;
      logic        slot_used;
      logic [15:0] sensor_id;
      logic signed [31:0] sensor_value;
   } tpr_req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic [3:0] sent_slot;
      logic       discard;
   } tpr_rsp_type;

   typedef struct packed {
      logic [4:0] physical_id;
      logic [7:0] start_byte;
      logic [7:0] header_data;
      logic [7:0] header_discard;
   } tpr_cfg_type;

   typedef struct packed {
      logic wr_slot;   // write the slot store from the input item
      logic build;     // latch the frame from the store read data
      logic slot_clr;  // return round-robin pointer to slot 0
      logic step;      // advance the byte serialiser
   } tpr_cmd_type;

   typedef struct packed {
      logic is_start;
      logic id_match;
      logic slot_ok;
      logic last;
   } tpr_stat_type;

   // 0xFF minus the end-around-carry sum of seven frame bytes
   function automatic logic [7:0] frame_checksum(input logic [55:0] bytes);
      logic [10:0] sum;
      logic [8:0]  fold;
      sum = '0;
      for (int i = 0; i < 7; i++) begin
         sum = sum + 11'(bytes[i*8 +: 8]);
      end
      fold = 9'(sum[7:0]) + 9'(sum[10:8]);
      fold = 9'(fold[7:0]) + 9'(fold[8]);
      return 8'(9'h0FF - fold);
   endfunction

endpackage

FILE: rtl/core/telemetry_poll_responder_unit.sv
// Telemetry poll responder: answers bus polls with byte-stuffed frames.
// A poll answer's first byte is offered in the send state, after the fetch state.
// Throughput: one item per cycle when it gives no answer; an answer holds the
// input until its last stuffed byte, sent one per cycle while rsp_ready is high.
// Reset (synchronous): slots empty, pointer at slot 0, registers at defaults.
// Depends on tpr_pkg, tpr_csr, tpr_ctrl and tpr_dpath.
module telemetry_poll_responder_unit
   import tpr_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tpr_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tpr_rsp_type rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   tpr_cfg_type  cfg;
   tpr_cmd_type  cmd;
   tpr_stat_type stat;

   tpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_payload.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tpr_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .req   (req_payload),
      .cfg   (cfg),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_payload)
   );

endmodule

FILE: rtl/core/tpr_csr.sv
// Configuration registers of the poll responder behind an APB-style port.
// Depends on tpr_pkg.
module tpr_csr
   import tpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output tpr_cfg_type cfg
);

   tpr_cfg_type cfg_ff, cfg_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_PHYS_ID:  cfg_in.physical_id    = pwdata[4:0];
            REG_START:    cfg_in.start_byte     = pwdata[7:0];
            REG_HDR_DATA: cfg_in.header_data    = pwdata[7:0];
            REG_HDR_DISC: cfg_in.header_discard = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.physical_id    <= 5'd0;
         cfg_ff.start_byte     <= 8'h7E;
         cfg_ff.header_data    <= 8'h10;
         cfg_ff.header_discard <= 8'h00;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_PHYS_ID:  prdata = 32'(cfg_ff.physical_id);
         REG_START:    prdata = 32'(cfg_ff.start_byte);
         REG_HDR_DATA: prdata = 32'(cfg_ff.header_data);
         REG_HDR_DISC: prdata = 32'(cfg_ff.header_discard);
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/tpr_ctrl.sv
// Controller of the poll responder: poll detection and frame sequencing.
// Depends on tpr_pkg; drives the datapath through tpr_cmd_type.
module tpr_ctrl
   import tpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_kind,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  tpr_stat_type stat,
   output tpr_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_SEND  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       expect_ff, expect_in;
   logic       req_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);
   assign req_take  = req_valid & req_ready;

   always_comb begin
      state_in  = state_ff;
      expect_in = expect_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_kind) begin
                  cmd.wr_slot = 1'b1;
               end else if (stat.is_start) begin
                  expect_in = 1'b1;
               end else if (expect_ff) begin
                  // only the byte right after a start byte is checked
                  expect_in = 1'b0;
                  if (stat.id_match) begin
                     if (stat.slot_ok) begin
                        state_in = ST_FETCH;
                     end else begin
                        cmd.slot_clr = 1'b1;
                     end
                  end
               end
            end
         end
         ST_FETCH: begin
            cmd.build = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               cmd.step = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         expect_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         expect_ff <= expect_in;
      end
   end

endmodule

FILE: rtl/core/tpr_dpath.sv
// Datapath of the poll responder: slot store, round-robin pointer,
// frame builder and byte-stuffing serialiser. Depends on tpr_pkg.
module tpr_dpath
   import tpr_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   input  tpr_req_type  req,
   input  tpr_cfg_type  cfg,
   input  tpr_cmd_type  cmd,
   output tpr_stat_type stat,
   output tpr_rsp_type  rsp
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [15:0] id_mem  [SLOTS];
   logic [31:0] val_mem [SLOTS];
   logic [15:0] rd_id_ff;
   logic [31:0] rd_val_ff;

   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [63:0]       frame_ff, frame_in;
   logic              disc_ff, disc_in;
   logic [3:0]        sent_slot_ff, sent_slot_in;
   logic [2:0]        bi_ff, bi_in;
   logic              esc_ff, esc_in;

   logic [SLOT_W-1:0] wr_idx;
   logic              wr_ok;
   logic              disc_b;
   logic [55:0]       frame_body;
   logic [7:0]        fb;
   logic              stuff;

   assign wr_idx = SLOT_W'(req.slot);
   assign wr_ok  = cmd.wr_slot && (32'(req.slot) < SLOTS);

   // slot store: one write port, one registered read at the pointer
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         id_mem[wr_idx]  <= req.sensor_id;
         val_mem[wr_idx] <= req.sensor_value;
      end
      rd_id_ff  <= id_mem[next_slot_ff];
      rd_val_ff <= val_mem[next_slot_ff];
   end

   assign disc_b     = (rd_id_ff == 16'd0);
   assign frame_body = {(disc_b ? 48'd0 : {rd_val_ff, rd_id_ff}),
                        (disc_b ? cfg.header_discard : cfg.header_data)};

   assign fb    = frame_ff[{bi_ff, 3'b000} +: 8];
   assign stuff = (fb == STUFF_FLAG) || (fb == STUFF_ESC);

   always_comb begin
      valid_in     = valid_ff;
      next_slot_in = next_slot_ff;
      frame_in     = frame_ff;
      disc_in      = disc_ff;
      sent_slot_in = sent_slot_ff;
      bi_in        = bi_ff;
      esc_in       = esc_ff;
      if (wr_ok) begin
         valid_in[wr_idx] = req.slot_used;
      end
      if (cmd.slot_clr) begin
         next_slot_in = '0;
      end
      if (cmd.build) begin
         frame_in     = {frame_checksum(frame_body), frame_body};
         disc_in      = disc_b;
         sent_slot_in = 4'(next_slot_ff);
         bi_in        = 3'd0;
         esc_in       = 1'b0;
         next_slot_in = (next_slot_ff == SLOT_W'(SLOTS - 1)) ? '0 : next_slot_ff + 1'b1;
      end
      if (cmd.step) begin
         if (stuff && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            bi_in  = bi_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_slot_ff <= '0;
         bi_ff        <= 3'd0;
         esc_ff       <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         next_slot_ff <= next_slot_in;
         bi_ff        <= bi_in;
         esc_ff       <= esc_in;
      end
      frame_ff     <= frame_in;
      disc_ff      <= disc_in;
      sent_slot_ff <= sent_slot_in;
   end

   assign stat.is_start = (req.rx_byte == cfg.start_byte);
   assign stat.id_match = (req.rx_byte[4:0] == cfg.physical_id);
   assign stat.slot_ok  = valid_ff[next_slot_ff];
   assign stat.last     = (bi_ff == 3'd7) && (!stuff || esc_ff);

   always_comb begin
      if (stuff && !esc_ff) begin
         rsp.tx_byte = STUFF_ESC;
      end else if (stuff) begin
         rsp.tx_byte = fb ^ STUFF_XOR;
      end else begin
         rsp.tx_byte = fb;
      end
      rsp.last      = stat.last;
      rsp.sent_slot = sent_slot_ff;
      rsp.discard   = disc_ff;
   end

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for telemetry_poll_responder_unit: polls, slot writes and
// register changes go in, and every stuffed frame byte is checked against a predictor.
// Depends on tpr_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;
   import tpr_pkg::*;

   localparam int CYCLE_LIMIT = 100000;
   localparam int REQ_W = $bits(tpr_req_type);

   // Mirrors the responder: register copies, slot table, round-robin pointer,
   // and the queue of frame bytes still owed on the result channel.
   class poll_scoreboard;
      logic [4:0]  phys_id;
      logic [7:0]  start_code;
      logic [7:0]  hdr_data;
      logic [7:0]  hdr_discard;
      bit          slot_live [16];
      logic [15:0] slot_id [16];
      logic [31:0] slot_value [16];
      logic [3:0]  slot_ptr;
      bit          armed;
      tpr_rsp_type frame_bytes_due [$];
      int          errors;

      function new();
         phys_id = '0;
         start_code = 8'h7E;
         hdr_data = 8'h10;
         hdr_discard = 8'h00;
         foreach (slot_live[i]) begin
            slot_live[i] = 0;
            slot_id[i] = '0;
            slot_value[i] = '0;
         end
         slot_ptr = '0;
         armed = 0;
         errors = 0;
      endfunction

      task report(string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         errors++;
      endtask

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_PHYS_ID:  phys_id = value[4:0];
            REG_START:    start_code = value[7:0];
            REG_HDR_DATA: hdr_data = value[7:0];
            REG_HDR_DISC: hdr_discard = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_request(tpr_req_type item);
         logic [7:0]  frame [8];
         int unsigned sum;
         bit          disc;
         tpr_rsp_type r;
         if (item.kind) begin
            slot_live[item.slot] = item.slot_used;
            slot_id[item.slot] = item.sensor_id;
            slot_value[item.slot] = item.sensor_value;
            return;
         end
         // a start byte always re-arms, even when already armed
         if (item.rx_byte == start_code) begin
            armed = 1;
            return;
         end
         if (!armed) return;
         armed = 0;
         if (item.rx_byte[4:0] != phys_id) return;
         if (!slot_live[slot_ptr]) begin
            slot_ptr = '0;
            return;
         end
         disc = (slot_id[slot_ptr] == 16'h0000);
         frame[0] = disc ? hdr_discard : hdr_data;
         {frame[2], frame[1]} = disc ? 16'h0000 : slot_id[slot_ptr];
         {frame[6], frame[5], frame[4], frame[3]} = disc ? 32'h0 : slot_value[slot_ptr];
         sum = 0;
         for (int i = 0; i < 7; i++) sum += frame[i];
         // fold the carries back in until the sum fits a byte
         while (sum > 255) sum = (sum & 255) + (sum >> 8);
         frame[7] = 8'(255 - sum);
         for (int i = 0; i < 8; i++) begin
            r.last = 0;
            r.sent_slot = slot_ptr;
            r.discard = disc;
            if (frame[i] == STUFF_FLAG || frame[i] == STUFF_ESC) begin
               r.tx_byte = STUFF_ESC;
               frame_bytes_due.push_back(r);
               r.tx_byte = frame[i] ^ STUFF_XOR;
            end else begin
               r.tx_byte = frame[i];
            end
            r.last = (i == 7);
            frame_bytes_due.push_back(r);
         end
         slot_ptr = slot_ptr + 4'd1;
      endfunction

      task check_response(tpr_rsp_type got);
         tpr_rsp_type want;
         if (frame_bytes_due.size() == 0) begin
            report($sformatf("unexpected result byte %02h", got.tx_byte));
            return;
         end
         want = frame_bytes_due.pop_front();
         if (got.tx_byte !== want.tx_byte)
            report($sformatf("tx_byte %02h, want %02h", got.tx_byte, want.tx_byte));
         if (got.last !== want.last)
            report($sformatf("last %b, want %b", got.last, want.last));
         if (got.sent_slot !== want.sent_slot)
            report($sformatf("sent_slot %0d, want %0d", got.sent_slot, want.sent_slot));
         if (got.discard !== want.discard)
            report($sformatf("discard %b, want %b", got.discard, want.discard));
      endtask

      function int pending();
         return frame_bytes_due.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   tpr_req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   tpr_rsp_type rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;
   poll_scoreboard sb;

   telemetry_poll_responder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random stalls, or a long hold-off while hold_left runs down
   initial begin
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_payload);
      end
   end

   // bytes that come up as 0x7E or 0x7D now and then, to exercise stuffing
   function automatic logic [31:0] stuffy_word();
      logic [31:0] w;
      w = $urandom;
      for (int i = 0; i < 4; i++)
         if ($urandom_range(4) == 0) w[i*8 +: 8] = $urandom_range(1) ? STUFF_FLAG : STUFF_ESC;
      return w;
   endfunction

   function automatic tpr_req_type rx_item(logic [7:0] b);
      tpr_req_type item;
      item = REQ_W'({$urandom, $urandom});
      item.kind = 1'b0;
      item.rx_byte = b;
      return item;
   endfunction

   function automatic tpr_req_type slot_item(logic [3:0] s, bit used, logic [15:0] id,
                                             logic [31:0] value);
      tpr_req_type item;
      item = REQ_W'({$urandom, $urandom});
      item.kind = 1'b1;
      item.slot = s;
      item.slot_used = used;
      item.sensor_id = id;
      item.sensor_value = value;
      return item;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(tpr_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_poll(bit hit);
      logic [4:0] low;
      low = hit ? sb.phys_id : sb.phys_id ^ 5'($urandom_range(31, 1));
      send_item(rx_item(sb.start_code));
      send_item(rx_item({3'($urandom), low}));
   endtask

   // write one register, then read it back
   task automatic apb_write(logic [1:0] idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == REG_PHYS_ID) ? 32'h1F : 32'hFF;
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock) penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      pwrite <= 0;
      penable <= 0;
      @(negedge clock) penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== (value & mask))
         sb.report($sformatf("register %0d reads %h, want %h", idx, prdata & mask,
                             value & mask));
      @(negedge clock);
      psel <= 0;
      penable <= 0;
      @(negedge clock);
   endtask

   task automatic set_registers(logic [31:0] pid, logic [31:0] sbyte, logic [31:0] hd,
                                logic [31:0] hx);
      apb_write(REG_PHYS_ID, pid);
      apb_write(REG_START, sbyte);
      apb_write(REG_HDR_DATA, hd);
      apb_write(REG_HDR_DISC, hx);
   endtask

   // drop valid, drain the owed bytes, then give the block time to go quiet
   task automatic settle();
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_item(slot_item(4'($urandom), $urandom_range(99) < 85,
                                ($urandom_range(9) == 0) ? 16'h0000 : 16'(stuffy_word()),
                                stuffy_word()));
            sent++;
         end else if (pick < 88) begin
            send_poll($urandom_range(99) < 85);
            sent += 2;
         end else begin
            send_item(rx_item(8'($urandom)));
            sent++;
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: reset register values, no idling
      send_poll(1);                                           // empty slot 0
      send_item(slot_item(4'd0, 1, 16'h7E7D, 32'h7D7E_FFFF)); // stuffed id and value
      send_item(slot_item(4'd1, 1, 16'h0000, 32'hFFFF_FFFF)); // discard frame
      send_item(slot_item(4'd2, 1, 16'hFFFF, 32'h8000_0000));
      send_item(slot_item(4'd3, 0, 16'h1234, 32'h7FFF_FFFF)); // empty slot
      send_item(slot_item(4'd15, 1, 16'hFFFF, 32'h7FFF_FFFF));
      send_item(rx_item(8'h00));                              // not armed: ignore
      send_item(rx_item(sb.start_code));                      // start twice re-arms
      send_item(rx_item(sb.start_code));
      send_item(rx_item(8'hE0));                              // high bits don't matter
      send_poll(0);                                           // wrong id
      send_item(rx_item(8'h00));                              // disarmed after mismatch
      send_poll(1);                                           // slot 1, discard
      send_poll(1);                                           // slot 2
      send_poll(1);                                           // slot 3 empty: back to 0
      send_poll(1);                                           // slot 0 again

      settle();
      set_registers(32'd31, 32'hFF, 32'h7E, 32'h7D);
      send_idle_pct = 67;
      stall_pct = 0;
      run_random(10);

      settle();
      set_registers(32'd0, 32'h00, 32'hFF, 32'hFF);
      send_idle_pct = 0;
      stall_pct = 67;
      run_random(10);

      settle();
      set_registers($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 20;
      stall_pct = 20;
      run_random(10);

      // fill every slot and poll past the end of the table to see the wrap
      settle();
      set_registers($urandom, 32'h7E, $urandom, $urandom);
      send_idle_pct = 0;
      stall_pct = 0;
      for (int s = 0; s < 16; s++)
         send_item(slot_item(4'(s), 1,
                             ($urandom_range(7) == 0) ? 16'h0000 : 16'(stuffy_word()),
                             stuffy_word()));
      for (int k = 0; k < 18; k++) send_poll(1);

      // hold the receiver off while polls keep coming, so the input backs up
      req_valid <= 0;
      @(posedge clock);
      hold_left = 400;
      @(negedge clock);
      for (int k = 0; k < 6; k++) send_poll(1);

      settle();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
